// ===== sv/lpfd_pkg.sv =====
package lpfd_pkg;

   // Fixed widths of the stream and result fields
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned KIND_WIDTH      = 2;
   localparam int unsigned RSP_DATA_WIDTH  = 2 * BYTE_WIDTH + 2 * WORD_WIDTH;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = WORD_WIDTH;

   // Frame layout: 4-byte length prefix, type byte, 4-byte request id
   localparam logic [WORD_WIDTH-1:0] HDR_BYTES  = WORD_WIDTH'(5);
   localparam logic [1:0]            WORD_LAST  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LEN          = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIG_ENDIAN_WORDS = 1'b1;

   localparam logic [WORD_WIDTH-1:0] MAX_LEN_RESET = WORD_WIDTH'(1048576);

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_HEADER    = 2'd0,
      KIND_BODY      = 2'd1,
      KIND_TOO_SMALL = 2'd2,
      KIND_TOO_LARGE = 2'd3
   } result_kind_type;

   // Shift one byte into a 32-bit field in the selected byte order
   function automatic logic [WORD_WIDTH-1:0] take_byte(
      input logic [WORD_WIDTH-1:0] acc,
      input logic [BYTE_WIDTH-1:0] data,
      input logic                  big_endian
   );
      logic [WORD_WIDTH-1:0] res;
      if (big_endian) begin
         res = {acc[WORD_WIDTH-BYTE_WIDTH-1:0], data};
      end else begin
         res = {data, acc[WORD_WIDTH-1:BYTE_WIDTH]};
      end
      return res;
   endfunction

endpackage

// ===== sv/length_prefixed_frame_deframer.sv =====
// Length-prefixed frame deframer.
// req_ channel: one stream byte per transaction. Each frame is a 4-byte length
// prefix, a type byte, a 4-byte request id and (length - 5) body bytes.
// rsp_ channel: one header transaction when the request id is complete, then
// one transaction per body byte; tlast marks the final transaction of a frame.
// A length below 5 or above the configured maximum gives one error transaction
// with tlast set, after which every incoming byte is dropped until reset.
// csr_ port: register 0 maximum frame length, register 1 big_endian_words;
// write only while the block is idle.
// A result is registered and appears on rsp_ in the cycle after the byte that causes
// it is accepted. Throughput: one byte per cycle while rsp_ does not stall, set by the
// single parse state machine that decodes each byte in the cycle it is accepted.
// Stall: the result register holds a pending transaction; req_tready stays
// high as long as that register is empty or is being drained in the same
// cycle, so a stalled receiver stalls the byte stream one for one.
// Reset: synchronous; returns to the length phase, clears the accumulators,
// empties the result register and restores both registers to their defaults.
module length_prefixed_frame_deframer
   import lpfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [BYTE_WIDTH-1:0]      req_tdata,   // [7:0] data_byte
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [7:0] frame_type, [39:8] request_ident, [71:40] frame_length, [79:72] body_byte
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic [KIND_WIDTH-1:0]      rsp_tuser,   // [1:0] result_kind
   output logic                       rsp_tlast,   // last_of_frame
   // configuration
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      PH_LENGTH = 3'd0,
      PH_TYPE   = 3'd1,
      PH_IDENT  = 3'd2,
      PH_BODY   = 3'd3,
      PH_DEAD   = 3'd4
   } phase_type;

   // configuration registers
   logic [WORD_WIDTH-1:0] max_len_ff;
   logic                  big_endian_ff;

   // parse state
   phase_type             phase_ff,     phase_in;
   logic [1:0]            byte_cnt_ff,  byte_cnt_in;
   logic [WORD_WIDTH-1:0] length_ff,    length_in;
   logic [WORD_WIDTH-1:0] ident_ff,     ident_in;
   logic [BYTE_WIDTH-1:0] type_ff,      type_in;
   logic [WORD_WIDTH-1:0] remaining_ff, remaining_in;

   // result register
   logic                  rsp_valid_ff;
   result_kind_type       rsp_kind_ff,  rsp_kind_in;
   logic [BYTE_WIDTH-1:0] rsp_type_ff,  rsp_type_in;
   logic [WORD_WIDTH-1:0] rsp_ident_ff, rsp_ident_in;
   logic [WORD_WIDTH-1:0] rsp_len_ff,   rsp_len_in;
   logic [BYTE_WIDTH-1:0] rsp_body_ff,  rsp_body_in;
   logic                  rsp_last_ff,  rsp_last_in;
   logic                  res_valid;

   logic                  req_fire;
   logic [WORD_WIDTH-1:0] len_shift;
   logic [WORD_WIDTH-1:0] ident_shift;
   logic [WORD_WIDTH-1:0] payload_len;
   logic [WORD_WIDTH-1:0] remaining_dec;

   // Accept a byte whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign len_shift     = take_byte(length_ff, req_tdata, big_endian_ff);
   assign ident_shift   = take_byte(ident_ff, req_tdata, big_endian_ff);
   assign payload_len   = length_ff - HDR_BYTES;
   assign remaining_dec = remaining_ff - WORD_WIDTH'(1);

   always_comb begin
      phase_in     = phase_ff;
      byte_cnt_in  = byte_cnt_ff;
      length_in    = length_ff;
      ident_in     = ident_ff;
      type_in      = type_ff;
      remaining_in = remaining_ff;
      res_valid    = 1'b0;
      rsp_kind_in  = KIND_HEADER;
      rsp_type_in  = type_ff;
      rsp_ident_in = ident_ff;
      rsp_len_in   = length_ff;
      rsp_body_in  = '0;
      rsp_last_in  = 1'b0;
      case (phase_ff)
         PH_LENGTH: begin
            length_in = len_shift;
            if (byte_cnt_ff == WORD_LAST) begin
               byte_cnt_in  = '0;
               rsp_type_in  = '0;
               rsp_ident_in = '0;
               rsp_len_in   = len_shift;
               rsp_last_in  = 1'b1;
               // the too-small check wins over the maximum check
               if (len_shift < HDR_BYTES) begin
                  res_valid   = 1'b1;
                  rsp_kind_in = KIND_TOO_SMALL;
                  phase_in    = PH_DEAD;
               end else if (len_shift > max_len_ff) begin
                  res_valid   = 1'b1;
                  rsp_kind_in = KIND_TOO_LARGE;
                  phase_in    = PH_DEAD;
               end else begin
                  phase_in = PH_TYPE;
               end
            end else begin
               byte_cnt_in = byte_cnt_ff + 2'd1;
            end
         end
         PH_TYPE: begin
            type_in     = req_tdata;
            ident_in    = '0;
            byte_cnt_in = '0;
            phase_in    = PH_IDENT;
         end
         PH_IDENT: begin
            ident_in = ident_shift;
            if (byte_cnt_ff == WORD_LAST) begin
               byte_cnt_in  = '0;
               remaining_in = payload_len;
               res_valid    = 1'b1;
               rsp_kind_in  = KIND_HEADER;
               rsp_ident_in = ident_shift;
               rsp_last_in  = (payload_len == '0);
               // empty body: the header closes the frame
               if (payload_len == '0) begin
                  phase_in  = PH_LENGTH;
                  length_in = '0;
               end else begin
                  phase_in = PH_BODY;
               end
            end else begin
               byte_cnt_in = byte_cnt_ff + 2'd1;
            end
         end
         PH_BODY: begin
            remaining_in = remaining_dec;
            res_valid    = 1'b1;
            rsp_kind_in  = KIND_BODY;
            rsp_body_in  = req_tdata;
            rsp_last_in  = (remaining_dec == '0);
            if (remaining_dec == '0) begin
               phase_in    = PH_LENGTH;
               length_in   = '0;
               byte_cnt_in = '0;
            end
         end
         default: begin
            // dropping phase: swallow every byte
         end
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_LEN_RESET;
         big_endian_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_LEN:          max_len_ff    <= csr_wdata;
            CSR_BIG_ENDIAN_WORDS: big_endian_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Parse state: advance on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LENGTH;
         byte_cnt_ff  <= '0;
         length_ff    <= '0;
         ident_ff     <= '0;
         type_ff      <= '0;
         remaining_ff <= '0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         byte_cnt_ff  <= byte_cnt_in;
         length_ff    <= length_in;
         ident_ff     <= ident_in;
         type_ff      <= type_in;
         remaining_ff <= remaining_in;
      end
   end

   // Result register: load on a producing byte, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_type_ff  <= rsp_type_in;
         rsp_ident_ff <= rsp_ident_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_body_ff  <= rsp_body_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_body_ff, rsp_len_ff, rsp_ident_ff, rsp_type_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The dropping phase is left only through reset
   a_dead_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD) |=> (phase_ff == PH_DEAD))
      else $error("deframer left the dropping phase without reset");

   // A body phase always has at least one byte outstanding
   a_body_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (remaining_ff != '0))
      else $error("body phase with no bytes remaining");

   // Error results close the frame and carry no type or id
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_TOO_SMALL || rsp_kind_ff == KIND_TOO_LARGE))
      |-> (rsp_last_ff && rsp_ident_ff == '0 && rsp_type_ff == '0))
      else $error("malformed error result");

   // An error result is always followed by the dropping phase
   a_error_then_dead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_TOO_SMALL || rsp_kind_ff == KIND_TOO_LARGE))
      |-> (phase_ff == PH_DEAD))
      else $error("error result without entering the dropping phase");

   // A header result never comes from a length below the header size
   a_header_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_HEADER) |-> (rsp_len_ff >= HDR_BYTES))
      else $error("header result with an undersized length");

endmodule
